FILE: design/fhp_pkg.sv
// fhp_pkg: shared types and constants for the flow header parser.
// No dependencies; used by every module of the block.
package fhp_pkg;

  localparam int PAYLOAD_LIMIT_DEF = 256;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int PAY_COUNT_MAX     = 511;
  localparam int FRAME_BYTES_MAX   = 65535;
  localparam int ETH_HDR_BYTES     = 14;
  localparam int VLAN_HDR_END      = 18;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_RECORD  = 1'b1;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  payload_byte;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  ip_protocol;
    logic [15:0] icmp_type_code;
    logic [15:0] frame_bytes;
    logic [8:0]  pay_count;
  } fhp_result_t;

  // Up to two results per input byte: payload first, then the record.
  typedef struct packed {
    logic        pay_vld;
    logic        rec_vld;
    fhp_result_t pay;
    fhp_result_t rec;
  } fhp_push_t;

endpackage

FILE: design/fhp_parser.sv
// fhp_parser: per-byte header state machine; builds payload and flow record results.
// Depends on fhp_pkg.
module fhp_parser import fhp_pkg::*; #(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  output fhp_push_t  push
);

  localparam int CAP_W = $clog2(PAYLOAD_LIMIT + 1);

  typedef enum logic [2:0] {
    PH_ETH, PH_VLAN, PH_IP, PH_ICMP, PH_TCP, PH_UDP, PH_PAYLOAD, PH_IDLE
  } phase_t;

  phase_t                 ph_r, ph_nxt;
  logic [LENGTH_BITS-1:0] off_r, off_nxt, off_inc, r, r4;
  logic [15:0]            etype_r, etype_nxt;
  logic [4:0]             l3_r, l3_nxt;
  logic [5:0]             ihb_r, ihb_nxt;
  logic [6:0]             l4_r, l4_nxt;
  logic [6:0]             l4hb_r, l4hb_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic [47:0]            dmac_r, dmac_nxt, smac_r, smac_nxt;
  logic [63:0]            ip_r, ip_nxt;
  logic [31:0]            ports_r, ports_nxt;
  logic [7:0]             proto_r, proto_nxt;
  logic [15:0]            icmp_r, icmp_nxt;
  logic                   hip_r, hip_nxt, hport_r, hport_nxt, hicmp_r, hicmp_nxt;
  logic                   pay_emit;
  logic [31:0]            off32, cap32;

  assign r  = off_r - LENGTH_BITS'(l3_r);
  assign r4 = off_r - LENGTH_BITS'(l4_r);
  assign off_inc = (off_r != '1) ? off_r + LENGTH_BITS'(1) : off_r;
  assign off32 = 32'(off_inc);

  always_comb begin
    ph_nxt = ph_r;      etype_nxt = etype_r;  l3_nxt = l3_r;     ihb_nxt = ihb_r;
    l4_nxt = l4_r;      l4hb_nxt = l4hb_r;    cap_nxt = cap_r;   dmac_nxt = dmac_r;
    smac_nxt = smac_r;  ip_nxt = ip_r;        ports_nxt = ports_r;
    proto_nxt = proto_r; icmp_nxt = icmp_r;
    hip_nxt = hip_r;    hport_nxt = hport_r;  hicmp_nxt = hicmp_r;
    pay_emit = 1'b0;
    case (ph_r)
      PH_ETH: begin
        if (off_r < LENGTH_BITS'(6)) dmac_nxt = {dmac_r[39:0], packet_byte};
        else if (off_r < LENGTH_BITS'(12)) smac_nxt = {smac_r[39:0], packet_byte};
        else etype_nxt = {etype_r[7:0], packet_byte};
        if (off_r == LENGTH_BITS'(13)) begin
          if (etype_nxt == ETYPE_VLAN || etype_nxt == ETYPE_QINQ) ph_nxt = PH_VLAN;
          else if (etype_nxt == ETYPE_IPV4) begin
            l3_nxt = 5'(ETH_HDR_BYTES);
            ph_nxt = PH_IP;
          end else ph_nxt = PH_IDLE;
        end
      end
      PH_VLAN: begin
        if (off_r == LENGTH_BITS'(16) || off_r == LENGTH_BITS'(17))
          etype_nxt = {etype_r[7:0], packet_byte};
        if (off_r >= LENGTH_BITS'(17)) begin
          if (etype_nxt == ETYPE_IPV4) begin
            l3_nxt = 5'(VLAN_HDR_END);
            ph_nxt = PH_IP;
          end else ph_nxt = PH_IDLE;
        end
      end
      PH_IP: begin
        if (r == '0) begin
          if (packet_byte[3:0] < 4'd5) ph_nxt = PH_IDLE;
          else ihb_nxt = {packet_byte[3:0], 2'b00};
        end else if (r == LENGTH_BITS'(9)) proto_nxt = packet_byte;
        else if (r >= LENGTH_BITS'(12) && r < LENGTH_BITS'(20))
          ip_nxt = {ip_r[55:0], packet_byte};
        if (r != '0 && r >= LENGTH_BITS'(19) &&
            (r + LENGTH_BITS'(1)) == LENGTH_BITS'(ihb_nxt)) begin
          hip_nxt = 1'b1;
          l4_nxt  = 7'(off_r + LENGTH_BITS'(1));
          if (proto_nxt == PROTO_ICMP) ph_nxt = PH_ICMP;
          else if (proto_nxt == PROTO_TCP) ph_nxt = PH_TCP;
          else if (proto_nxt == PROTO_UDP) ph_nxt = PH_UDP;
          else ph_nxt = PH_IDLE;
        end
      end
      PH_ICMP: begin
        if (r4 < LENGTH_BITS'(2)) icmp_nxt = {icmp_r[7:0], packet_byte};
        if (r4 == LENGTH_BITS'(7)) begin
          hicmp_nxt = 1'b1;
          ph_nxt = PH_IDLE;
        end
      end
      PH_TCP: begin
        if (r4 < LENGTH_BITS'(4)) ports_nxt = {ports_r[23:0], packet_byte};
        else if (r4 == LENGTH_BITS'(12)) l4hb_nxt = {1'b0, packet_byte[7:4], 2'b00};
        else if (r4 == LENGTH_BITS'(19)) begin
          hport_nxt = 1'b1;
          if (l4hb_r < 7'd20) ph_nxt = PH_IDLE;
          else if (l4hb_r == 7'd20) ph_nxt = PH_PAYLOAD;
        end else if (r4 > LENGTH_BITS'(19) &&
                     (r4 + LENGTH_BITS'(1)) == LENGTH_BITS'(l4hb_r)) ph_nxt = PH_PAYLOAD;
      end
      PH_UDP: begin
        if (r4 < LENGTH_BITS'(4)) ports_nxt = {ports_r[23:0], packet_byte};
        if (r4 == LENGTH_BITS'(7)) begin
          l4hb_nxt = 7'd8;
          hport_nxt = 1'b1;
          ph_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (cap_r < CAP_W'(PAYLOAD_LIMIT)) begin
          cap_nxt  = cap_r + CAP_W'(1);
          pay_emit = 1'b1;
        end
      end
      default: ;
    endcase
    off_nxt = off_inc;
  end

  assign cap32 = 32'(cap_nxt);

  always_comb begin
    push = '0;
    push.pay_vld = accept && pay_emit;
    push.pay.record_kind  = KIND_PAYLOAD;
    push.pay.payload_byte = packet_byte;
    push.rec_vld = accept && last_byte && (off32 >= 32'(ETH_HDR_BYTES));
    push.rec.record_kind    = KIND_RECORD;
    push.rec.dst_mac        = dmac_nxt;
    push.rec.src_mac        = smac_nxt;
    push.rec.src_ip         = hip_nxt ? ip_nxt[63:32] : '0;
    push.rec.dst_ip         = hip_nxt ? ip_nxt[31:0] : '0;
    push.rec.sport          = hport_nxt ? ports_nxt[31:16] : '0;
    push.rec.dport          = hport_nxt ? ports_nxt[15:0] : '0;
    push.rec.ip_protocol    = hip_nxt ? proto_nxt : '0;
    push.rec.icmp_type_code = hicmp_nxt ? icmp_nxt : '0;
    push.rec.frame_bytes    = (off32 > 32'(FRAME_BYTES_MAX)) ? 16'(FRAME_BYTES_MAX) : off32[15:0];
    push.rec.pay_count      = (cap32 > 32'(PAY_COUNT_MAX)) ? 9'(PAY_COUNT_MAX) : cap32[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      ph_r <= PH_ETH;  off_r <= '0;    etype_r <= '0;  l3_r <= 5'(ETH_HDR_BYTES);
      ihb_r <= '0;     l4_r <= '0;     l4hb_r <= '0;   cap_r <= '0;
      dmac_r <= '0;    smac_r <= '0;   ip_r <= '0;     ports_r <= '0;
      proto_r <= '0;   icmp_r <= '0;
      hip_r <= 1'b0;   hport_r <= 1'b0; hicmp_r <= 1'b0;
    end else if (accept) begin
      ph_r <= ph_nxt;  off_r <= off_nxt; etype_r <= etype_nxt; l3_r <= l3_nxt;
      ihb_r <= ihb_nxt; l4_r <= l4_nxt;  l4hb_r <= l4hb_nxt;   cap_r <= cap_nxt;
      dmac_r <= dmac_nxt; smac_r <= smac_nxt; ip_r <= ip_nxt; ports_r <= ports_nxt;
      proto_r <= proto_nxt; icmp_r <= icmp_nxt;
      hip_r <= hip_nxt; hport_r <= hport_nxt; hicmp_r <= hicmp_nxt;
    end
  end

endmodule

FILE: design/fhp_out_queue.sv
// fhp_out_queue: small result queue taking up to two results a cycle, giving one while out_stall is low.
// Depends on fhp_pkg.
module fhp_out_queue import fhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fhp_push_t   push,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output fhp_result_t out_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  fhp_result_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0]     wp_r, rp_r, wp_nxt, rp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        npush;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // room is kept for two requests, so the input side never overruns
  assign full      = (cnt_r > (PW+1)'(QUEUE_DEPTH - 2));
  assign npush     = 2'(push.pay_vld) + 2'(push.rec_vld);

  always_comb begin
    wp_nxt  = wp_r + PW'(npush);
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(npush) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.pay_vld) begin
      mem_r[wp_r] <= push.pay;
      if (push.rec_vld) mem_r[wp_r + PW'(1)] <= push.rec;
    end else if (push.rec_vld) begin
      mem_r[wp_r] <= push.rec;
    end
  end

endmodule

FILE: design/flow_header_parser_unit.sv
// Flow header parser top level: byte-wide frame input, result queue output.
// Depends on fhp_pkg, fhp_parser, fhp_out_queue.
//
// Input: one frame byte per request (in_packet_byte, in_last_byte on the final
// byte). Output: payload byte results (kind 0) for TCP/UDP payload up to
// PAYLOAD_LIMIT bytes, then one flow record (kind 1) on the frame's last byte.
// Frames shorter than 14 bytes produce nothing.
// Throughput: one input byte per cycle while in_stall is low. A result reaches out_
// the cycle after its byte is taken if the queue is empty, else behind queued ones.
// A last byte that is also a payload byte gives two results, drained one per cycle
// (out_stall low) from a 4-entry queue that raises in_stall when under two are free.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the Ethernet header; the end of every frame does the same to the parser.
// While out_stall is high the front result holds; input keeps flowing until
// the queue fills.
module flow_header_parser_unit import fhp_pkg::*; #(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [7:0]  out_payload_byte,
  output logic [47:0] out_dst_mac,
  output logic [47:0] out_src_mac,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dst_ip,
  output logic [15:0] out_sport,
  output logic [15:0] out_dport,
  output logic [7:0]  out_ip_protocol,
  output logic [15:0] out_icmp_type_code,
  output logic [15:0] out_frame_bytes,
  output logic [8:0]  out_pay_count
);

  fhp_push_t   push;
  fhp_result_t res;
  logic        full, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  fhp_parser #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT), .LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk, .rst_n, .accept,
    .packet_byte(in_packet_byte), .last_byte(in_last_byte), .push
  );

  fhp_out_queue u_queue (
    .clk, .rst_n, .push, .full, .out_valid, .out_stall, .out_data(res)
  );

  assign out_record_kind    = res.record_kind;
  assign out_payload_byte   = res.payload_byte;
  assign out_dst_mac        = res.dst_mac;
  assign out_src_mac        = res.src_mac;
  assign out_src_ip         = res.src_ip;
  assign out_dst_ip         = res.dst_ip;
  assign out_sport          = res.sport;
  assign out_dport          = res.dport;
  assign out_ip_protocol    = res.ip_protocol;
  assign out_icmp_type_code = res.icmp_type_code;
  assign out_frame_bytes    = res.frame_bytes;
  assign out_pay_count      = res.pay_count;

endmodule

FILE: design/fhp_checker.sv
// fhp_checker: port-level assertions for flow_header_parser_unit, with its bind.
// Depends on fhp_pkg.
module fhp_checker import fhp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_kind,
  input logic [7:0]  out_payload_byte,
  input logic [47:0] out_dst_mac,
  input logic [15:0] out_frame_bytes,
  input logic [8:0]  out_pay_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_record_kind) && $stable(out_frame_bytes))
    else $error("stalled result changed");

  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_PAYLOAD |->
      out_dst_mac == '0 && out_frame_bytes == '0 && out_pay_count == '0)
    else $error("payload result carries record fields");

  a_rec_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_RECORD |->
      out_frame_bytes >= 16'(ETH_HDR_BYTES) && out_payload_byte == '0)
    else $error("record from short frame");

  // first edge out of reset: queue empty
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("queue not empty after reset");

endmodule

bind flow_header_parser_unit fhp_checker u_fhp_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_record_kind,
  .out_payload_byte, .out_dst_mac, .out_frame_bytes, .out_pay_count
);
